@@ rtl/pkd_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette key pixel decoder package
// Shared command codes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pkd_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int KeyBytes = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // an input item is accepted this cycle
        logic step;   // advance the palette search by one entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic launch; // the accepted item completed a key and a search must run
        logic done;   // the search ends this cycle (hit or last entry missed)
    } t_stat;

endpackage

@@ rtl/palette_key_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// Palette key pixel decoder
// Turns character-keyed palette images into packed 32-bit ARGB pixels.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Start, load and
// non-final key characters do not raise busy. A character that completes a key
// searches the palette in load order, one entry per cycle through the palette
// memory read port, and holds busy until a hit or until the last entry has
// missed; an empty palette answers without a search. Each
// result appears for a single cycle with o_result_strobe and cannot be held
// off, so the receiver must take it in that cycle.
// ----------------------------------------------------------------------------
module palette_key_pixel_decoder #(
    parameter int TABLE_DEPTH   = 64,
    parameter int MAX_KEY_CHARS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_key_char,
    input  logic [31:0] i_entry_key,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_transparent,
    output logic [31:0] o_pixel_word,
    output logic [1:0]  o_status,
    output logic        o_result_strobe
);

    pkd_pkg::t_cmd  cmd;
    pkd_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    pkd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    pkd_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_key_char    (i_key_char),
        .i_entry_key   (i_entry_key),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_transparent (i_transparent),
        .o_pixel_word  (o_pixel_word),
        .o_status      (o_status),
        .o_strobe      (o_result_strobe)
    );

endmodule

@@ rtl/pkd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Palette key pixel decoder controller
// Accepts items and sequences the palette search, one entry per cycle.
// ----------------------------------------------------------------------------
module pkd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output pkd_pkg::t_cmd o_cmd,
    input  pkd_pkg::t_stat i_stat
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.take = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_start;
                if (i_start && i_stat.launch) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/pkd_datapath.sv @@
// ----------------------------------------------------------------------------
// Palette key pixel decoder datapath
// Holds the palette memories, gathers key characters and compares keys.
// ----------------------------------------------------------------------------
module pkd_datapath #(
    parameter int TABLE_DEPTH   = 64,
    parameter int MAX_KEY_CHARS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pkd_pkg::t_cmd  i_cmd,
    output pkd_pkg::t_stat o_stat,
    input  logic           i_cfg_valid,
    input  logic [2:0]     i_cfg_data,
    input  logic [1:0]     i_command,
    input  logic [7:0]     i_key_char,
    input  logic [31:0]    i_entry_key,
    input  logic [7:0]     i_red_in,
    input  logic [7:0]     i_green_in,
    input  logic [7:0]     i_blue_in,
    input  logic           i_transparent,
    output logic [31:0]    o_pixel_word,
    output logic [1:0]     o_status,
    output logic           o_strobe
);

    localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW  = $clog2(TABLE_DEPTH + 1);
    localparam int KeyLimInt = (MAX_KEY_CHARS < pkd_pkg::KeyBytes) ?
                               MAX_KEY_CHARS : pkd_pkg::KeyBytes;
    localparam logic [2:0] KeyLim = 3'(KeyLimInt);
    localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

    logic [31:0] r_key_mem   [TABLE_DEPTH];
    logic [31:0] r_color_mem [TABLE_DEPTH];

    logic [2:0]      r_cpp;
    logic [CntW-1:0] r_entry_count;
    logic [1:0]      r_char_pos;
    logic [23:0]     r_partial_key;
    logic [31:0]     r_key;
    logic [CntW-1:0] r_idx;
    logic [31:0]     r_rd_key;
    logic [31:0]     r_rd_color;
    logic            r_cmp_vld;
    logic            r_cmp_last;
    logic [31:0]     r_pixel_word;
    logic [1:0]      r_status;
    logic            r_strobe;

    logic [2:0]  eff_cpp;
    logic        complete;
    logic [31:0] key_word;
    logic        table_full;
    logic        issue;
    logic        hit;
    logic        last_miss;
    logic        do_write;
    logic        n_strobe;

    always_comb begin
        eff_cpp = r_cpp;
        if (eff_cpp == 3'd0) begin
            eff_cpp = 3'd1;
        end
        if (eff_cpp > KeyLim) begin
            eff_cpp = KeyLim;
        end
    end

    assign complete = (({1'b0, r_char_pos} + 3'd1) >= eff_cpp);

    always_comb begin
        case (r_char_pos)
            2'd0:    key_word = {8'd0, r_partial_key[23:8], i_key_char};
            2'd1:    key_word = {8'd0, r_partial_key[23:16], i_key_char, r_partial_key[7:0]};
            2'd2:    key_word = {8'd0, i_key_char, r_partial_key[15:0]};
            default: key_word = {i_key_char, r_partial_key};
        endcase
    end

    assign table_full = (r_entry_count == DepthCnt);
    assign do_write   = i_cmd.take && (i_command == pkd_pkg::CMD_LOAD) && !table_full;
    assign issue      = i_cmd.step && (r_idx < r_entry_count);
    assign hit        = r_cmp_vld && (r_rd_key == r_key);
    assign last_miss  = r_cmp_vld && r_cmp_last && !hit;

    // A result follows a refused load, a key finished against an empty palette,
    // or the end of a search.
    assign n_strobe = (i_cmd.take && (i_command == pkd_pkg::CMD_LOAD) && table_full)
                   || (i_cmd.take && (i_command == pkd_pkg::CMD_PIXEL) && complete
                       && (r_entry_count == '0))
                   || (i_cmd.step && (hit || last_miss));

    assign o_stat.launch = (i_command == pkd_pkg::CMD_PIXEL) && complete
                           && (r_entry_count != '0);
    assign o_stat.done   = hit || last_miss;

    // Palette memories: one write port for loads, one registered read for the search.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_key_mem[r_entry_count[AddrW-1:0]]   <= i_entry_key;
            r_color_mem[r_entry_count[AddrW-1:0]] <= i_transparent ? 32'd0 :
                {8'hFF, i_red_in, i_green_in, i_blue_in};
        end
        if (issue) begin
            r_rd_key   <= r_key_mem[r_idx[AddrW-1:0]];
            r_rd_color <= r_color_mem[r_idx[AddrW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpp         <= 3'd1;
            r_entry_count <= '0;
            r_char_pos    <= 2'd0;
            r_partial_key <= 24'd0;
            r_idx         <= '0;
            r_cmp_vld     <= 1'b0;
            r_cmp_last    <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                r_cpp <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_cmp_vld <= 1'b0;
                case (i_command)
                    pkd_pkg::CMD_START: begin
                        r_entry_count <= '0;
                        r_char_pos    <= 2'd0;
                        r_partial_key <= 24'd0;
                    end
                    pkd_pkg::CMD_LOAD: begin
                        if (!table_full) begin
                            r_entry_count <= r_entry_count + CntW'(1);
                        end
                    end
                    pkd_pkg::CMD_PIXEL: begin
                        if (!complete) begin
                            r_char_pos    <= r_char_pos + 2'd1;
                            r_partial_key <= key_word[23:0];
                        end else begin
                            r_char_pos    <= 2'd0;
                            r_partial_key <= 24'd0;
                            r_idx         <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step) begin
                r_cmp_vld  <= issue && !(hit || last_miss);
                r_cmp_last <= ((r_idx + CntW'(1)) == r_entry_count);
                if (issue) begin
                    r_idx <= r_idx + CntW'(1);
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pixel_word <= 32'd0;
            r_status     <= (i_command == pkd_pkg::CMD_LOAD) ? pkd_pkg::ST_FULL
                                                             : pkd_pkg::ST_MISS;
            r_key        <= key_word;
        end else if (i_cmd.step && hit) begin
            r_pixel_word <= r_rd_color;
            r_status     <= pkd_pkg::ST_FOUND;
        end else if (i_cmd.step && last_miss) begin
            r_pixel_word <= 32'd0;
            r_status     <= pkd_pkg::ST_MISS;
        end
    end

    assign o_pixel_word = r_pixel_word;
    assign o_status     = r_status;
    assign o_strobe     = r_strobe;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= DepthCnt)
        else $error("palette entry count exceeds the table depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_char_pos} < KeyLim || r_char_pos == 2'd0)
        else $error("key character position beyond the key limit");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && o_stat.done) |=> r_strobe)
        else $error("search ended without a result");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != pkd_pkg::ST_FOUND) |-> (r_pixel_word == 32'd0))
        else $error("failed lookup carries a non-zero pixel");

endmodule
